>>> rtl/core/e2q_pkg.sv
// ============================================================================
// e2q_pkg: shared types and constants for the Euler-to-quaternion converter
// Holds the quarter-wave sine ROM image, built at elaboration, the fixed-point
// types used along the pipeline and the pipeline depth.
// ============================================================================
package e2q_pkg;

    // Full-circle sine table resolution, in index bits
    localparam int SINE_TABLE_BITS = 11;

    // Quarter wave: entries 0..QTR_SIZE inclusive, magnitude only
    localparam int QTR_BITS = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    localparam int ROM_W    = 15;

    // Register stages from input beat to output register
    localparam int NSTG = 6;

    // Lookup slots: sine and cosine of each half angle
    localparam int LK_SX = 0;
    localparam int LK_CX = 1;
    localparam int LK_SY = 2;
    localparam int LK_CY = 3;
    localparam int LK_SZ = 4;
    localparam int LK_CZ = 5;
    localparam int NLK   = 6;

    // Quaternion component slots
    localparam int QC_W = 0;
    localparam int QC_X = 1;
    localparam int QC_Y = 2;
    localparam int QC_Z = 3;
    localparam int NQC  = 4;

    typedef logic signed [15:0]  q15_t;
    typedef logic        [QTR_BITS:0] rom_addr_t;
    typedef logic signed [31:0]  pair_t;
    typedef logic signed [47:0]  q345_t;

    typedef struct packed {
        rom_addr_t addr;
        logic      neg;
    } lkup_t;

    localparam longint unsigned LO32   = 64'h0000_0000_FFFF_FFFF;
    localparam longint unsigned PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Series divisors (2k)(2k+1) for k = 1..14
    localparam longint unsigned TAYLOR_DIV [14] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    // (a * b) >> 60 on unsigned Q60 values, split into 32-bit halves
    function automatic longint unsigned mul_q60(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = a & LO32;
        ah  = a >> 32;
        bl  = b & LO32;
        bh  = b >> 32;
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + (lh & LO32) + (hl & LO32);
        lo  = (ll & LO32) | (mid << 32);
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 4) | (lo >> 60);
    endfunction

    // sin(r * pi / 32768) in Q1.15 by Taylor series, rounded, held to 32767
    function automatic logic [ROM_W-1:0] quarter_sine(input longint unsigned r);
        longint unsigned x, x2, term, sum, v;
        x    = (PI_Q60 >> 15) * r;
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 14; k++) begin
            term = mul_q60(term, x2) / TAYLOR_DIV[k - 1];
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + (64'd1 << 44)) >> 45;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[ROM_W-1:0];
    endfunction

    // Packed quarter-wave image, entry i at bits [i*ROM_W +: ROM_W]
    function automatic logic [(QTR_SIZE+1)*ROM_W-1:0] build_qsin();
        logic [(QTR_SIZE+1)*ROM_W-1:0] img;
        longint unsigned r;
        img = '0;
        for (int i = 0; i <= QTR_SIZE; i++) begin
            r = longint'(i) << (16 - SINE_TABLE_BITS);
            img[i*ROM_W +: ROM_W] = quarter_sine(r);
        end
        return img;
    endfunction

    localparam logic [(QTR_SIZE+1)*ROM_W-1:0] QSIN_ROM = build_qsin();

endpackage

>>> rtl/core/euler_angles_to_quaternion.sv
// ============================================================================
// euler_angles_to_quaternion: fixed-point Euler XYZ to rotation quaternion
// Halves three binary angles, looks up half-angle sine and cosine in a
// quarter-wave ROM, forms the quaternion products exactly and rounds each
// component once to saturated Q1.15.
// ============================================================================
//
//  channel   dir  tdata fields (low bit up)                  beats
//  s_axis    in   angle_x[15:0] angle_y[31:16] angle_z[47:32]  one per item
//  m_axis    out  quat_w[15:0] quat_x[31:16] quat_y[47:32]     one per item
//                 quat_z[63:48]
//
//  Six register stages: halving/addressing, ROM read, pair products,
//  triple products, sums, round and saturate into the output register.
//  One beat is taken every cycle when the output drains.
//  Each stage holds its beat only while the stage after it is full, so a
//  stalled output does not stop beats entering empty stages upstream.
//  aresetn (synchronous, active low) clears the stage valid bits only.
//
module euler_angles_to_quaternion
    import e2q_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // angle_x, angle_y, angle_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);

    // ---- stage handshake ---------------------------------------------------
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (en[0]) begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];

    // ---- stage 1: halve angles, map to quarter-wave addresses -------------
    // Halving truncates toward zero; cosine is the entry a quarter turn on.
    function automatic lkup_t map_idx(input logic [SINE_TABLE_BITS-1:0] idx);
        lkup_t lk;
        logic [QTR_BITS-1:0] low;
        low = idx[QTR_BITS-1:0];
        lk.neg = idx[SINE_TABLE_BITS-1];
        if (idx[SINE_TABLE_BITS-2]) begin
            lk.addr = rom_addr_t'(QTR_SIZE) - {1'b0, low};
        end else begin
            lk.addr = {1'b0, low};
        end
        return lk;
    endfunction

    lkup_t lk_reg [NLK];
    lkup_t lk_next [NLK];

    always_comb begin
        logic signed [16:0]          sum17;
        logic [15:0]                 half;
        logic [SINE_TABLE_BITS-1:0]  idx;
        for (int a = 0; a < 3; a++) begin
            sum17 = {s_axis_tdata[16*a+15], s_axis_tdata[16*a +: 16]}
                    + {16'd0, s_axis_tdata[16*a+15]};
            half  = sum17[16:1];
            idx   = half[15 -: SINE_TABLE_BITS];
            lk_next[2*a]     = map_idx(idx);
            lk_next[2*a + 1] = map_idx(idx + SINE_TABLE_BITS'(QTR_SIZE));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            lk_reg <= lk_next;
        end
    end

    // ---- stage 2: ROM read with sign applied -------------------------------
    q15_t trig_reg [NLK];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < NLK; i++) begin
                if (lk_reg[i].neg) begin
                    trig_reg[i] <= -q15_t'({1'b0, QSIN_ROM[lk_reg[i].addr*ROM_W +: ROM_W]});
                end else begin
                    trig_reg[i] <= q15_t'({1'b0, QSIN_ROM[lk_reg[i].addr*ROM_W +: ROM_W]});
                end
            end
        end
    end

    // ---- stage 3: x/y pair products, carry z terms -------------------------
    pair_t p_cc_reg, p_ss_reg, p_cs_reg, p_sc_reg;
    q15_t  sz3_reg, cz3_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            p_cc_reg <= trig_reg[LK_CX] * trig_reg[LK_CY];
            p_ss_reg <= trig_reg[LK_SX] * trig_reg[LK_SY];
            p_cs_reg <= trig_reg[LK_CX] * trig_reg[LK_SY];
            p_sc_reg <= trig_reg[LK_SX] * trig_reg[LK_CY];
            sz3_reg  <= trig_reg[LK_SZ];
            cz3_reg  <= trig_reg[LK_CZ];
        end
    end

    // ---- stage 4: triple products, exact Q3.45 -----------------------------
    // Operands are widened first so the product is formed at 48 bits.
    q345_t t_a_reg [NQC];
    q345_t t_b_reg [NQC];

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            t_a_reg[QC_W] <= q345_t'(p_cc_reg) * q345_t'(cz3_reg);
            t_b_reg[QC_W] <= q345_t'(p_ss_reg) * q345_t'(sz3_reg);
            t_a_reg[QC_X] <= q345_t'(p_sc_reg) * q345_t'(cz3_reg);
            t_b_reg[QC_X] <= q345_t'(p_cs_reg) * q345_t'(sz3_reg);
            t_a_reg[QC_Y] <= q345_t'(p_cs_reg) * q345_t'(cz3_reg);
            t_b_reg[QC_Y] <= q345_t'(p_sc_reg) * q345_t'(sz3_reg);
            t_a_reg[QC_Z] <= q345_t'(p_cc_reg) * q345_t'(sz3_reg);
            t_b_reg[QC_Z] <= q345_t'(p_ss_reg) * q345_t'(cz3_reg);
        end
    end

    // ---- stage 5: component sums -------------------------------------------
    q345_t sum_reg [NQC];

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sum_reg[QC_W] <= t_a_reg[QC_W] + t_b_reg[QC_W];
            sum_reg[QC_X] <= t_a_reg[QC_X] - t_b_reg[QC_X];
            sum_reg[QC_Y] <= t_a_reg[QC_Y] + t_b_reg[QC_Y];
            sum_reg[QC_Z] <= t_a_reg[QC_Z] - t_b_reg[QC_Z];
        end
    end

    // ---- stage 6: round half up to Q1.15, saturate -------------------------
    q15_t quat_next [NQC];
    q15_t quat_reg  [NQC];

    always_comb begin
        q345_t              rnd;
        logic signed [17:0] r18;
        for (int c = 0; c < NQC; c++) begin
            rnd = sum_reg[c] + q345_t'(48'd1 << 29);
            r18 = rnd[47:30];
            if (r18 > 18'sd32767) begin
                quat_next[c] = 16'sh7FFF;
            end else if (r18 < -18'sd32768) begin
                quat_next[c] = 16'sh8000;
            end else begin
                quat_next[c] = r18[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            quat_reg <= quat_next;
        end
    end

    assign m_axis_tdata = {quat_reg[QC_Z], quat_reg[QC_Y], quat_reg[QC_X], quat_reg[QC_W]};

endmodule

>>> rtl/core/e2q_check.sv
// ============================================================================
// e2q_check: port-level checks for the Euler-to-quaternion converter
// Tracks beats in flight and checks output hold, drain behavior and that
// results never outrun or overfill the pipeline.
// ============================================================================
module e2q_check
    import e2q_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // beats accepted but not yet delivered
    logic [3:0] inflight_reg, inflight_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb begin
        inflight_next = inflight_reg + {3'd0, in_beat} - {3'd0, out_beat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // empty output stage never blocks the input
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with output stage empty");

    // no result without a beat in flight
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> inflight_reg != 4'd0)
        else $error("result without matching input beat");

    // pipeline never holds more beats than stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'(NSTG))
        else $error("more beats in flight than pipeline stages");

endmodule

bind euler_angles_to_quaternion e2q_check u_e2q_check (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
